// ===== rtl/itce_pkg.sv =====
// ----------------------------------------------------------------------------
// itce_pkg: shared types and constants for the IPv4/TCP checksum engine
// Holds the transfer payload structs, the per-packet sum record and the
// ones-complement adder used by both the accumulator and the finishing stage.
// ----------------------------------------------------------------------------
package itce_pkg;

    // Packet word positions and protocol constants.
    localparam logic [14:0] POS_MAX       = 15'h7FFF;
    localparam logic [14:0] IP_CSUM_WORD  = 15'd5;
    localparam logic [14:0] ADDR_FIRST    = 15'd6;
    localparam logic [14:0] ADDR_LAST     = 15'd9;
    localparam logic [14:0] TCP_CSUM_WORD = 15'd8;
    localparam logic [3:0]  IHL_MIN       = 4'd5;
    localparam logic [15:0] PROTO_TCP     = 16'd6;
    localparam logic [15:0] MIN_TCP_BYTES = 16'd20;
    localparam logic [1:0]  ONE_BYTE      = 2'd1;

    // One input transfer: a packet word with its byte count and end flag.
    typedef struct packed {
        logic [15:0] data_word;
        logic [1:0]  valid_bytes;
        logic        last;
    } t_in_item;

    // One result transfer.
    typedef struct packed {
        logic [15:0] ip_checksum;
        logic [15:0] tcp_checksum;
        logic        malformed;
    } t_out_item;

    // Packet totals handed from the accumulator to the finishing stage.
    typedef struct packed {
        logic [15:0] ip_sum;
        logic [15:0] seg_sum;
        logic [15:0] seg_bytes;
        logic        malformed;
    } t_sums;

    // Ones-complement addition with end-around carry.
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

// ===== rtl/itce_accum.sv =====
// ----------------------------------------------------------------------------
// itce_accum: per-word checksum accumulator
// Tracks the word position and IP header length of the current packet and
// folds each word into the IP header sum and the TCP segment sum.
// ----------------------------------------------------------------------------
module itce_accum (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  itce_pkg::t_in_item i_item,
    input  logic              i_update,
    output itce_pkg::t_sums   o_sums
);

    logic [14:0] r_pos;
    logic [3:0]  r_hw;
    logic        r_bad;
    logic [15:0] r_ip_sum;
    logic [15:0] r_seg_sum;
    logic [15:0] r_seg_bytes;

    logic [14:0] n_pos;
    logic [3:0]  n_hw;
    logic        n_bad;
    logic [15:0] n_ip_sum;
    logic [15:0] n_seg_sum;
    logic [15:0] n_seg_bytes;

    logic [15:0] word;
    logic        one_byte;
    logic        is_first;
    logic [4:0]  hdr_len;
    logic        in_hdr;
    logic [14:0] seg_idx;
    logic        short_pkt;

    // Next-state logic for one word.
    always_comb begin
        one_byte = (i_item.valid_bytes == itce_pkg::ONE_BYTE);
        word     = one_byte ? {i_item.data_word[15:8], 8'h00} : i_item.data_word;
        is_first = (r_pos == 15'd0);
        n_hw     = is_first ? word[11:8] : r_hw;
        n_bad    = is_first ? (word[11:8] < itce_pkg::IHL_MIN) : r_bad;
        hdr_len  = {n_hw, 1'b0};
        in_hdr   = (r_pos < {10'd0, hdr_len});
        seg_idx  = r_pos - {10'd0, hdr_len};

        n_ip_sum    = r_ip_sum;
        n_seg_sum   = r_seg_sum;
        n_seg_bytes = r_seg_bytes;
        if (in_hdr) begin
            // IP header word; addresses also feed the pseudo-header.
            if (r_pos != itce_pkg::IP_CSUM_WORD) begin
                n_ip_sum = itce_pkg::oc_add(r_ip_sum, word);
            end
            if (r_pos >= itce_pkg::ADDR_FIRST && r_pos <= itce_pkg::ADDR_LAST) begin
                n_seg_sum = itce_pkg::oc_add(r_seg_sum, word);
            end
        end else begin
            // Segment word; the TCP checksum field counts as zero.
            if (seg_idx != itce_pkg::TCP_CSUM_WORD) begin
                n_seg_sum = itce_pkg::oc_add(r_seg_sum, word);
            end
            n_seg_bytes = r_seg_bytes + (one_byte ? 16'd1 : 16'd2);
        end

        n_pos = (r_pos == itce_pkg::POS_MAX) ? r_pos : r_pos + 15'd1;

        short_pkt = (n_seg_bytes < itce_pkg::MIN_TCP_BYTES) && (n_pos != itce_pkg::POS_MAX);

        o_sums.ip_sum    = n_ip_sum;
        o_sums.seg_sum   = n_seg_sum;
        o_sums.seg_bytes = n_seg_bytes;
        o_sums.malformed = n_bad || short_pkt;
    end

    // State registers; the last word of a packet returns them to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_hw        <= '0;
            r_bad       <= 1'b0;
            r_ip_sum    <= '0;
            r_seg_sum   <= '0;
            r_seg_bytes <= '0;
        end else if (i_update) begin
            if (i_item.last) begin
                r_pos       <= '0;
                r_hw        <= '0;
                r_bad       <= 1'b0;
                r_ip_sum    <= '0;
                r_seg_sum   <= '0;
                r_seg_bytes <= '0;
            end else begin
                r_pos       <= n_pos;
                r_hw        <= n_hw;
                r_bad       <= n_bad;
                r_ip_sum    <= n_ip_sum;
                r_seg_sum   <= n_seg_sum;
                r_seg_bytes <= n_seg_bytes;
            end
        end
    end

endmodule

// ===== rtl/ipv4_tcp_checksum_engine.sv =====
// ----------------------------------------------------------------------------
// ipv4_tcp_checksum_engine: IPv4 header and TCP checksum calculator
// Sums a packet streamed as 16-bit words and reports both checksums in a
// result transfer that follows the transfer carrying the packet's last word.
// ----------------------------------------------------------------------------
// The engine takes one packet word per cycle, with no gaps between packets,
// while it does not stall the input. A word is transferred into an input
// register, from which the accumulator folds it into the running sums. The
// last word of a packet also loads the packet totals into a packet-total
// register, and the result register is filled from there, so a result passes
// the input, packet-total and result registers before it is offered.
// While a stalled result fills the packet-total and result registers, the
// last word of the next packet waits in the input register and stalls the
// input; other words keep flowing.
// Only the last word of a packet produces a result transfer; ip_checksum and
// tcp_checksum are the inverted ones-complement sums, and malformed flags an
// IHL below five or fewer than twenty bytes after the IP header.
module ipv4_tcp_checksum_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  itce_pkg::t_in_item   i_item,
    output logic                 o_valid,
    input  logic                 i_stall,
    output itce_pkg::t_out_item  o_item
);

    logic                r_a_valid;
    itce_pkg::t_in_item  r_a_item;
    logic                r_b_valid;
    itce_pkg::t_sums     r_b_sums;
    logic                r_out_valid;
    itce_pkg::t_out_item r_out_item;

    logic                out_ready;
    logic                b_ready;
    logic                a_move;
    logic                a_ready;
    itce_pkg::t_sums     sums;
    itce_pkg::t_out_item n_out_item;
    logic [15:0]         tcp_partial;
    logic [15:0]         seg_total;

    // Pipeline flow control: each stage loads when empty or when it drains.
    assign out_ready = !r_out_valid || !i_stall;
    assign b_ready   = !r_b_valid || out_ready;
    assign a_move    = r_a_valid && (!r_a_item.last || b_ready);
    assign a_ready   = !r_a_valid || a_move;
    assign o_stall   = !a_ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a_item <= i_item;
        end
    end

    // Running sums over the packet.
    itce_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (r_a_item),
        .i_update(a_move),
        .o_sums  (sums)
    );

    // Packet-total register, loaded by the last word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= a_move && r_a_item.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && a_move && r_a_item.last) begin
            r_b_sums <= sums;
        end
    end

    // Pseudo-header protocol and length, then inversion.
    always_comb begin
        tcp_partial             = itce_pkg::oc_add(r_b_sums.seg_sum, itce_pkg::PROTO_TCP);
        seg_total               = itce_pkg::oc_add(tcp_partial, r_b_sums.seg_bytes);
        n_out_item.ip_checksum  = ~r_b_sums.ip_sum;
        n_out_item.tcp_checksum = ~seg_total;
        n_out_item.malformed    = r_b_sums.malformed;
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_b_valid) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

endmodule

// ===== verif/itce_checker.sv =====
// ----------------------------------------------------------------------------
// itce_checker: scoreboard for the IPv4/TCP checksum engine
// Watches the word and result channels, sums each packet the way the engine
// must, and compares every result transfer field by field with the oldest
// predicted result. Hands a failure count and the number of packets
// still awaiting a result to the testbench top.
// ----------------------------------------------------------------------------
module itce_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  itce_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  itce_pkg::t_out_item i_out_item,
    output int                  o_fail_count,
    output int                  o_pending
);

    // Running packet state of the prediction.
    logic [14:0] word_idx;
    logic [3:0]  ihl;
    logic [15:0] ip_acc;
    logic [15:0] seg_acc;
    logic [15:0] seg_len;
    logic        ihl_bad;

    itce_pkg::t_out_item checksum_q[$];
    itce_pkg::t_out_item want;
    int                  fails;

    initial begin
        fails = 0;
    end

    // Ones-complement sum of two words with the carry folded back in.
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] full;
        full = {1'b0, a} + {1'b0, b};
        return full[15:0] + {15'd0, full[16]};
    endfunction

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        fails++;
    endtask

    task automatic clear_packet();
        word_idx = '0;
        ihl      = '0;
        ip_acc   = '0;
        seg_acc  = '0;
        seg_len  = '0;
        ihl_bad  = 1'b0;
    endtask

    // Folds one accepted word into the packet sums; on the last word the
    // expected checksums are queued and the packet state is cleared.
    task automatic absorb_word(input itce_pkg::t_in_item it);
        logic [15:0]         w;
        logic [15:0]         nbytes;
        logic [14:0]         hdr_len;
        logic [15:0]         seg_total;
        logic                short_seg;
        itce_pkg::t_out_item exp_item;

        w      = it.data_word;
        nbytes = (it.valid_bytes == itce_pkg::ONE_BYTE) ? 16'd1 : 16'd2;
        if (it.valid_bytes == itce_pkg::ONE_BYTE) begin
            w[7:0] = 8'h00;
        end

        // The IHL nibble of the first word fixes the IP header length.
        if (word_idx == 15'd0) begin
            ihl     = w[11:8];
            ihl_bad = (ihl < itce_pkg::IHL_MIN);
        end
        hdr_len = {10'd0, ihl, 1'b0};

        if (word_idx < hdr_len) begin
            if (word_idx != itce_pkg::IP_CSUM_WORD) begin
                ip_acc = ones_add(ip_acc, w);
            end
            // Source and destination addresses feed the pseudo-header.
            if (word_idx >= itce_pkg::ADDR_FIRST && word_idx <= itce_pkg::ADDR_LAST) begin
                seg_acc = ones_add(seg_acc, w);
            end
        end else begin
            if (word_idx - hdr_len != itce_pkg::TCP_CSUM_WORD) begin
                seg_acc = ones_add(seg_acc, w);
            end
            seg_len = seg_len + nbytes;
        end

        if (word_idx < itce_pkg::POS_MAX) begin
            word_idx = word_idx + 15'd1;
        end

        if (it.last) begin
            seg_total = ones_add(ones_add(seg_acc, itce_pkg::PROTO_TCP), seg_len);
            // A saturated position means the segment was long, even if the
            // byte count wrapped to a small value.
            short_seg = (seg_len < itce_pkg::MIN_TCP_BYTES) && (word_idx < itce_pkg::POS_MAX);
            exp_item.ip_checksum  = ~ip_acc;
            exp_item.tcp_checksum = ~seg_total;
            exp_item.malformed    = ihl_bad | short_seg;
            checksum_q.push_back(exp_item);
            clear_packet();
        end
    endtask

    // Compare result transfers first, then absorb the word transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_packet();
            checksum_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (checksum_q.size() == 0) begin
                    report_mismatch($sformatf("result %h with no packet pending",
                                              i_out_item));
                end else begin
                    want = checksum_q.pop_front();
                    if (i_out_item.ip_checksum !== want.ip_checksum) begin
                        report_mismatch($sformatf("ip_checksum got %h expected %h",
                                                  i_out_item.ip_checksum,
                                                  want.ip_checksum));
                    end
                    if (i_out_item.tcp_checksum !== want.tcp_checksum) begin
                        report_mismatch($sformatf("tcp_checksum got %h expected %h",
                                                  i_out_item.tcp_checksum,
                                                  want.tcp_checksum));
                    end
                    if (i_out_item.malformed !== want.malformed) begin
                        report_mismatch($sformatf("malformed got %b expected %b",
                                                  i_out_item.malformed,
                                                  want.malformed));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                absorb_word(i_in_item);
            end
        end
        o_fail_count <= fails;
        o_pending    <= checksum_q.size();
    end

endmodule

// ===== verif/tb_ipv4_tcp_checksum_engine.sv =====
// ----------------------------------------------------------------------------
// tb_ipv4_tcp_checksum_engine: testbench for the IPv4/TCP checksum engine
// Streams directed corner packets and then random packets (well-formed,
// short and bad IHL) into the engine with bursty word transfers and a
// varying result stall, while the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_ipv4_tcp_checksum_engine;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_WORDS   = 1400;
    localparam int DRAIN_CYCLES   = 20;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} t_stall_mode;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    itce_pkg::t_in_item  i_item  = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    itce_pkg::t_out_item o_item;

    int          fail_count;
    int          pending;
    int          burst_left = 0;
    int          words_sent = 0;
    int          idle_cycles = 0;
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_left = 0;
    int          stall_tick = 0;

    ipv4_tcp_checksum_engine u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    itce_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_item    (i_item),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_item   (o_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result stall: stretches of one pattern at a time, including none.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                stall_left = $urandom_range(20, 300);
            end
            stall_left--;
            stall_tick++;
            case (stall_mode)
                STALL_NONE:     i_stall <= 1'b0;
                STALL_RANDOM:   i_stall <= ($urandom_range(0, 2) == 0);
                STALL_PERIODIC: i_stall <= ((stall_tick % 7) < 3);
                default:        i_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Ends the run when no transfer happens on either channel for too long.
    initial begin
        @(posedge i_rst_n);
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Test completed with failures");
        $finish;
    end

    // Offers one word and waits for its transfer; bursts are separated by
    // random gaps, some of them zero.
    task automatic push_word(input itce_pkg::t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        burst_left--;
        words_sent++;
    endtask

    task automatic push_fields(input logic [15:0] data, input logic [1:0] nbytes,
                               input logic is_last);
        itce_pkg::t_in_item it;
        it.data_word   = data;
        it.valid_bytes = nbytes;
        it.last        = is_last;
        push_word(it);
    endtask

    // Holds the word channel idle until every queued result has come out.
    task automatic wait_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Sends one packet with the given IHL and segment length in bytes.
    task automatic send_packet(input logic [3:0] ihl, input int seg_bytes);
        int                 total;
        int                 fill;
        int                 pick;
        itce_pkg::t_in_item it;
        total = ihl * 2 + (seg_bytes + 1) / 2;
        if (total == 0) begin
            total = 1;
        end
        fill = $urandom_range(0, 9);
        for (int p = 0; p < total; p++) begin
            // Mostly random content, sometimes all zeros or all ones.
            case (fill)
                0:       it.data_word = 16'h0000;
                1:       it.data_word = 16'hFFFF;
                default: it.data_word = 16'($urandom);
            endcase
            if (p == 0) begin
                it.data_word[11:8] = ihl;
            end
            it.last        = (p == total - 1);
            it.valid_bytes = 2'd2;
            pick = $urandom_range(0, 31);
            if (pick == 0) begin
                it.valid_bytes = 2'd0;
            end else if (pick == 1) begin
                it.valid_bytes = 2'd3;
            end else if (pick == 2 && !it.last) begin
                it.valid_bytes = itce_pkg::ONE_BYTE;
            end
            if (it.last && seg_bytes[0]) begin
                it.valid_bytes = itce_pkg::ONE_BYTE;
            end
            push_word(it);
        end
    endtask

    task automatic send_random_packet();
        int          kind;
        logic [3:0]  ihl;
        int          seg_bytes;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            // Mostly well-formed, often right around the minimum segment size.
            ihl       = (kind < 50) ? 4'd5 : 4'($urandom_range(5, 15));
            seg_bytes = ($urandom_range(0, 3) == 0) ? $urandom_range(19, 21)
                                                    : $urandom_range(20, 80);
        end else if (kind < 85) begin
            ihl       = 4'($urandom_range(5, 15));
            seg_bytes = $urandom_range(0, 19);
        end else begin
            ihl       = 4'($urandom_range(0, 4));
            seg_bytes = $urandom_range(0, 40);
        end
        send_packet(ihl, seg_bytes);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // IHL zero, single zero word: the word already belongs to the segment.
        push_fields(16'h0000, 2'd2, 1'b1);
        // Single odd byte of all ones; the lower byte must be ignored.
        push_fields(16'hFFFF, itce_pkg::ONE_BYTE, 1'b1);
        // Byte counts of three and zero both mean a full word.
        push_fields(16'hFFFF, 2'd3, 1'b0);
        push_fields(16'hFFFF, 2'd0, 1'b1);
        // IHL one: two header words, then one odd segment byte.
        push_fields(16'h4100, 2'd2, 1'b0);
        push_fields(16'hFFFF, 2'd2, 1'b0);
        push_fields(16'h12FF, itce_pkg::ONE_BYTE, 1'b1);
        // Odd byte before the end of the packet.
        push_fields(16'h40AB, itce_pkg::ONE_BYTE, 1'b0);
        push_fields(16'h8001, 2'd2, 1'b1);
        // IHL four: the checksum word and two address words lie in the header.
        push_fields(16'h4400, 2'd2, 1'b0);
        for (int p = 1; p < 9; p++) begin
            push_fields(16'hF00F ^ 16'(p), 2'd2, p == 8);
        end
        // IHL zero over nine words: the TCP checksum word is skipped.
        push_fields(16'h40FF, 2'd2, 1'b0);
        for (int p = 1; p < 9; p++) begin
            push_fields(16'hFFFF - 16'(p), 2'd2, p == 8);
        end
        wait_results();

        words_sent = 0;
        while (words_sent < RANDOM_WORDS) begin
            send_random_packet();
            if (words_sent >= RANDOM_WORDS / 2 && words_sent < RANDOM_WORDS / 2 + 40) begin
                wait_results();
            end
        end

        wait_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== ipv4_tcp_checksum_engine.f =====
rtl/itce_pkg.sv
rtl/itce_accum.sv
rtl/ipv4_tcp_checksum_engine.sv
verif/itce_checker.sv
verif/tb_ipv4_tcp_checksum_engine.sv
